// File: design/ip_tcp_udp_checksum_assert.svh
// Assertion macros for the checksum block, clocked on clk with active-low reset rst_n.
`ifndef IP_TCP_UDP_CHECKSUM_ASSERT_SVH
`define IP_TCP_UDP_CHECKSUM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ipcs_pkg.sv
// Shared constants and helper functions for the IPv4/UDP/TCP checksum block.
`timescale 1ns / 1ps

package ipcs_pkg;

    localparam logic [1:0]  MODE_UDP    = 2'd1;
    localparam logic [1:0]  MODE_TCP    = 2'd2;

    localparam logic [31:0] PROTO_UDP   = 32'd17;
    localparam logic [31:0] PROTO_TCP   = 32'd6;

    localparam logic [15:0] IP_SUM_IDX  = 16'd5;
    localparam logic [15:0] ADDR_FIRST  = 16'd6;
    localparam logic [15:0] ADDR_LAST   = 16'd9;
    localparam logic [15:0] TCP_LEN_IDX = 16'd1;
    localparam logic [15:0] UDP_LEN_OFF = 16'd2;
    localparam logic [15:0] UDP_SUM_OFF = 16'd3;
    localparam logic [15:0] TCP_SUM_OFF = 16'd8;
    localparam logic [15:0] WORD_MAX    = 16'hFFFF;

    // Contribution of one segment word at word offset off, given the segment length in bytes.
    function automatic logic [15:0] seg_word_term(input logic [15:0] off,
                                                  input logic [15:0] w,
                                                  input logic [15:0] len);
        logic [17:0] byte_off;
        logic [17:0] len_ext;
        logic [15:0] term;
        byte_off = {1'b0, off, 1'b0};
        len_ext  = {2'b00, len};
        if (byte_off + 18'd2 <= len_ext)
            term = w;
        else if (byte_off + 18'd1 == len_ext)
            term = {w[15:8], 8'h00};
        else
            term = 16'h0000;
        return term;
    endfunction

    // Fold a 32-bit sum twice to 16 bits and invert.
    function automatic logic [15:0] fold_checksum(input logic [31:0] acc);
        logic [16:0] s;
        s = {1'b0, acc[31:16]} + {1'b0, acc[15:0]};
        s = s + {16'h0000, s[16]};
        return ~s[15:0];
    endfunction

endpackage

// File: design/ip_tcp_udp_checksum.sv
// Streaming RFC 1071 checksum over an IPv4 packet: IP header, UDP or TCP with pseudo-header.
`timescale 1ns / 1ps
`include "ip_tcp_udp_checksum_assert.svh"
// Timing: an accepted word waits in the input register and is folded into the running state when it
//   retires; for the last word of a packet the checksum is then registered and offered from the result register.
// Throughput: one word per cycle; the input register and the result register part the two
//   sides, so the only stall is a last word meeting a checksum still held by checksum_stall.
// Reset (rst_n low, asynchronous): accumulator, word index, lengths and mode clear to zero,
//   both valid flags drop, so the block is ready for a word once reset is released.

module ip_tcp_udp_checksum
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    output logic        word_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] packet_word,
    input  logic        first_word,
    input  logic        last_word,
    output logic        checksum_valid,
    input  logic        checksum_stall,
    output logic [15:0] checksum
);
    import ipcs_pkg::*;

    // Input register: one word waiting to be folded into the running state.
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  s1_opcode_reg;
    logic [15:0] s1_word_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;

    // Running packet state.
    logic [31:0] acc_reg, acc_next;
    logic [15:0] word_index_reg, word_index_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [15:0] segment_length_reg, segment_length_next;
    logic [1:0]  active_mode_reg, active_mode_next;
    logic        length_known_reg, length_known_next;
    logic [1:0]  pend_valid_reg, pend_valid_next;
    logic [15:0] pend_word_reg [2];
    logic [15:0] pend_word_next [2];

    // Result register.
    logic        checksum_valid_reg, checksum_valid_next;
    logic [15:0] checksum_reg, checksum_next;

    logic        word_accept;
    logic        out_free;
    logic        proc;

    // Per-word working values, after a first word has restarted the state.
    logic [31:0] acc_base;
    logic [15:0] idx;
    logic [3:0]  hw;
    logic [1:0]  mode;
    logic [15:0] seg_len;
    logic        known;
    logic [1:0]  pv;
    logic        is_udp, is_tcp;
    logic [15:0] hw2, hb;
    logic        set_len_tcp, set_len_udp, set_len;
    logic [15:0] new_len, len_eff;
    logic        known_eff;
    logic        in_seg, sum_field;
    logic [15:0] off, seg_val;
    logic [15:0] ip_term, addr_term, len_term, pend0_term, pend1_term, seg_term;
    logic [31:0] acc_calc;

    // A last word may only retire when the result register is free or being drained.
    assign out_free    = !checksum_valid_reg || !checksum_stall;
    assign proc        = s1_valid_reg && (!s1_last_reg || out_free);
    assign word_stall  = s1_valid_reg && !proc;
    assign word_accept = word_valid && !word_stall;

    assign checksum_valid = checksum_valid_reg;
    assign checksum       = checksum_reg;

    // Restart the state on a first word, otherwise continue from the registers.
    always_comb
    begin
        if (s1_first_reg)
        begin
            mode    = s1_opcode_reg;
            hw      = s1_word_reg[11:8];
            idx     = 16'h0000;
            seg_len = 16'h0000;
            known   = 1'b0;
            pv      = 2'b00;
            case (s1_opcode_reg)
                MODE_UDP: acc_base = PROTO_UDP;
                MODE_TCP: acc_base = PROTO_TCP;
                default:  acc_base = 32'h0000_0000;
            endcase
        end
        else
        begin
            mode     = active_mode_reg;
            hw       = header_words_reg;
            idx      = word_index_reg;
            seg_len  = segment_length_reg;
            known    = length_known_reg;
            pv       = pend_valid_reg;
            acc_base = acc_reg;
        end
    end

    // Contributions of this word; opcode three falls into IP header mode.
    always_comb
    begin
        is_udp = (mode == MODE_UDP);
        is_tcp = (mode == MODE_TCP);
        hw2    = {11'h000, hw, 1'b0};
        hb     = {10'h000, hw, 2'b00};

        ip_term   = (!is_udp && !is_tcp && idx < hw2 && idx != IP_SUM_IDX)
                    ? s1_word_reg : 16'h0000;
        addr_term = ((is_udp || is_tcp) && idx >= ADDR_FIRST && idx <= ADDR_LAST)
                    ? s1_word_reg : 16'h0000;

        // TCP length comes from the total length word, clamped at zero; UDP from its header.
        set_len_tcp = is_tcp && (idx == TCP_LEN_IDX);
        set_len_udp = is_udp && (idx == hw2 + UDP_LEN_OFF);
        set_len     = set_len_tcp || set_len_udp;
        if (set_len_tcp)
            new_len = (s1_word_reg >= hb) ? (s1_word_reg - hb) : 16'h0000;
        else
            new_len = s1_word_reg;
        len_eff   = set_len ? new_len : seg_len;
        known_eff = known || set_len;
        len_term  = set_len ? new_len : 16'h0000;

        // Flush early segment words once the length is known.
        pend0_term = (set_len && pv[0]) ? seg_word_term(16'd0, pend_word_reg[0], new_len)
                                        : 16'h0000;
        pend1_term = (set_len && pv[1]) ? seg_word_term(16'd1, pend_word_reg[1], new_len)
                                        : 16'h0000;

        in_seg    = (is_udp || is_tcp) && (idx >= hw2);
        off       = idx - hw2;
        sum_field = (is_udp && off == UDP_SUM_OFF) || (is_tcp && off == TCP_SUM_OFF);
        seg_val   = sum_field ? 16'h0000 : s1_word_reg;
        seg_term  = (in_seg && known_eff) ? seg_word_term(off, seg_val, len_eff) : 16'h0000;

        acc_calc = acc_base + {16'h0000, ip_term} + {16'h0000, addr_term}
                 + {16'h0000, len_term} + {16'h0000, pend0_term}
                 + {16'h0000, pend1_term} + {16'h0000, seg_term};
    end

    // Next state: advance only when the held word retires.
    always_comb
    begin
        s1_valid_next       = word_accept ? 1'b1 : (proc ? 1'b0 : s1_valid_reg);
        acc_next            = acc_reg;
        word_index_next     = word_index_reg;
        header_words_next   = header_words_reg;
        segment_length_next = segment_length_reg;
        active_mode_next    = active_mode_reg;
        length_known_next   = length_known_reg;
        pend_valid_next     = pend_valid_reg;
        pend_word_next[0]   = pend_word_reg[0];
        pend_word_next[1]   = pend_word_reg[1];
        checksum_valid_next = checksum_valid_reg && checksum_stall;
        checksum_next       = checksum_reg;

        if (proc)
        begin
            acc_next            = acc_calc;
            word_index_next     = (idx == WORD_MAX) ? idx : idx + 16'd1;
            header_words_next   = hw;
            segment_length_next = len_eff;
            active_mode_next    = mode;
            length_known_next   = known_eff;
            pend_valid_next     = set_len ? 2'b00 : pv;
            if (in_seg && !known_eff && off < 16'd2)
            begin
                pend_word_next[off[0]]  = seg_val;
                pend_valid_next[off[0]] = 1'b1;
            end
            if (s1_last_reg)
            begin
                checksum_valid_next = 1'b1;
                checksum_next       = fold_checksum(acc_calc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            acc_reg            <= 32'h0000_0000;
            word_index_reg     <= 16'h0000;
            header_words_reg   <= 4'h0;
            segment_length_reg <= 16'h0000;
            active_mode_reg    <= 2'b00;
            length_known_reg   <= 1'b0;
            pend_valid_reg     <= 2'b00;
            checksum_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg       <= s1_valid_next;
            acc_reg            <= acc_next;
            word_index_reg     <= word_index_next;
            header_words_reg   <= header_words_next;
            segment_length_reg <= segment_length_next;
            active_mode_reg    <= active_mode_next;
            length_known_reg   <= length_known_next;
            pend_valid_reg     <= pend_valid_next;
            checksum_valid_reg <= checksum_valid_next;
        end
    end

    // Payload registers: hold unless a transfer or a retiring word updates them.
    always_ff @(posedge clk)
    begin
        if (word_accept)
        begin
            s1_opcode_reg <= opcode;
            s1_word_reg   <= packet_word;
            s1_first_reg  <= first_word;
            s1_last_reg   <= last_word;
        end
        pend_word_reg[0] <= pend_word_next[0];
        pend_word_reg[1] <= pend_word_next[1];
        checksum_reg     <= checksum_next;
    end

    `IPCS_ASSERT_NOW(a_stall_cause, word_stall,
        s1_valid_reg && s1_last_reg && checksum_valid_reg && checksum_stall,
        "input stalled without a blocked last word")
    `IPCS_ASSERT_NEXT(a_last_gives_result, proc && s1_last_reg,
        checksum_valid_reg,
        "retired last word did not present a checksum")
    `IPCS_ASSERT_NEXT(a_index_saturates, proc && !s1_first_reg && word_index_reg == WORD_MAX,
        word_index_reg == WORD_MAX,
        "word index wrapped past saturation")
    `IPCS_ASSERT_NOW(a_pend_only_unknown, pend_valid_reg != 2'b00,
        !length_known_reg,
        "pending segment words held after the length was known")

endmodule
